// File: design/smc_pkg.sv
package smc_pkg;

  // Stack geometry; the count width follows from the depth.
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned LEVEL_W     = 5;
  localparam int unsigned WIDE_W      = 49;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef enum logic [2:0] {
    OP_INVALID = 3'd0,
    OP_PUSH    = 3'd1,
    OP_ADD     = 3'd2,
    OP_SUB     = 3'd3,
    OP_MUL     = 3'd4,
    OP_DIV     = 3'd5,
    OP_OUT     = 3'd6,
    OP_HALT    = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OUTPUT    = 3'd1,
    ST_HALTED    = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_DIVZERO   = 3'd5,
    ST_INVALID   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2
  } cell_cmd_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_MUL    = 3'd2,
    S_DIV    = 3'd3,
    S_FINISH = 3'd4
  } state_e;

  typedef struct packed {
    op_e  operation;
    q16_t immediate;
  } in_t;

  typedef struct packed {
    status_e            status;
    q16_t               result_value;
    logic [LEVEL_W-1:0] stack_level;
  } out_t;

  localparam wide_t Q_MAX = wide_t'(64'sd2147483647);
  localparam wide_t Q_MIN = -wide_t'(64'sd2147483648);

  // Clamp a wide signed intermediate to the Q16.16 range.
  function automatic q16_t sat_q(input wide_t v);
    q16_t r;
    if (v > Q_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < Q_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: design/smc_cell.sv
module smc_cell (
  input  logic                 clk_i,
  input  smc_pkg::cell_cmd_e   cmd_i,
  input  smc_pkg::q16_t        up_i,
  input  smc_pkg::q16_t        down_i,
  output smc_pkg::q16_t        val_o
);
  import smc_pkg::*;

  q16_t val_q;
  q16_t val_d;

  // A push takes the entry from the neighbor nearer the top, a pop the one below.
  always_comb begin
    case (cmd_i)
      CELL_PUSH: val_d = up_i;
      CELL_POP:  val_d = down_i;
      default:   val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// File: design/smc_div.sv
module smc_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  smc_pkg::q16_t dividend_i,
  input  smc_pkg::q16_t divisor_i,
  output logic          done_o,
  output smc_pkg::q16_t quotient_o
);
  import smc_pkg::*;

  localparam int unsigned NUM_W  = 48;
  localparam int unsigned STEP_W = $clog2(NUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [32:0]       rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [31:0]       den_q, den_d;
  logic              neg_q, neg_d;

  logic [31:0] dvd_mag;
  logic [31:0] dsr_mag;
  logic [32:0] rem_shift;
  logic        ge;
  wide_t       signed_quo;

  assign dvd_mag = dividend_i[31] ? (~dividend_i + 32'd1) : dividend_i;
  assign dsr_mag = divisor_i[31] ? (~divisor_i + 32'd1) : divisor_i;

  // Restoring division on magnitudes: one quotient bit per cycle, the
  // numerator bits shift out of the quotient register as quotient bits enter.
  assign rem_shift = {rem_q[31:0], quo_q[NUM_W-1]};
  assign ge        = rem_shift >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = {dvd_mag, 16'b0};
      den_d  = dsr_mag;
      neg_d  = dividend_i[31] ^ divisor_i[31];
    end else if (busy_q) begin
      rem_d  = ge ? (rem_shift - {1'b0, den_q}) : rem_shift;
      quo_d  = {quo_q[NUM_W-2:0], ge};
      step_d = step_q + STEP_W'(1);
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign signed_quo = neg_q ? -wide_t'({1'b0, quo_q}) : wide_t'({1'b0, quo_q});
  assign quotient_o = sat_q(signed_quo);
  assign done_o     = done_q;

endmodule

// File: design/stack_machine_calculator.sv
// Q16.16 stack calculator, one instruction per input beat and one result
// beat per instruction. The stack is a row of cells that shift toward or away
// from the top, so the two top entries are always at fixed places. Push, add,
// subtract, out, halt and every fault pass S_IDLE, S_DECODE and S_FINISH;
// multiply adds S_MUL for the register after the 32x32 multiplier; divide
// waits in S_DIV for the divider, which yields one quotient bit a cycle.
// The next input beat is taken in the cycle after a result is loaded into the
// output register, even while that result still waits to be taken.
module stack_machine_calculator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  smc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output smc_pkg::out_t out_data_o
);
  import smc_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;
  op_e              op_q, op_d;
  q16_t             imm_q, imm_d;
  status_e          status_q, status_d;
  q16_t             res_q, res_d;
  logic signed [63:0] prod_q, prod_d;

  q16_t      cell_val [STACK_DEPTH];
  cell_cmd_e top_cmd;
  cell_cmd_e rest_cmd;
  q16_t      new_top;

  q16_t  top_val;
  q16_t  second_val;
  logic  div_start;
  logic  div_done;
  q16_t  div_quo;
  logic  load_out;
  logic  full;
  logic  below_two;
  wide_t add_wide;
  wide_t sub_wide;

  assign top_val    = cell_val[0];
  assign second_val = cell_val[1];
  assign full       = count_q == CNT_W'(STACK_DEPTH);
  assign below_two  = count_q < CNT_W'(2);
  assign add_wide   = wide_t'(second_val) + wide_t'(top_val);
  assign sub_wide   = wide_t'(second_val) - wide_t'(top_val);
  assign new_top    = (op_q == OP_PUSH) ? imm_q : res_q;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    q16_t up_val;
    q16_t down_val;
    if (i == 0) begin : g_top
      assign up_val = new_top;
    end else begin : g_mid
      assign up_val = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_val = '0;
    end else begin : g_inner
      assign down_val = cell_val[i+1];
    end
    smc_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  ((i == 0) ? top_cmd : rest_cmd),
      .up_i   (up_val),
      .down_i (down_val),
      .val_o  (cell_val[i])
    );
  end

  smc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (second_val),
    .divisor_i  (top_val),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    op_d        = op_q;
    imm_d       = imm_q;
    status_d    = status_q;
    res_d       = res_q;
    prod_d      = prod_q;
    in_ready_o  = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    top_cmd     = CELL_HOLD;
    rest_cmd    = CELL_HOLD;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = in_data_i.operation;
          imm_d   = in_data_i.immediate;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        status_d = ST_OK;
        res_d    = '0;
        state_d  = S_FINISH;
        case (op_q)
          OP_PUSH: begin
            if (full) begin
              status_d = ST_OVERFLOW;
            end
          end
          OP_ADD, OP_SUB: begin
            if (below_two) begin
              status_d = ST_UNDERFLOW;
            end else begin
              res_d = sat_q((op_q == OP_ADD) ? add_wide : sub_wide);
            end
          end
          OP_MUL: begin
            if (below_two) begin
              status_d = ST_UNDERFLOW;
            end else begin
              prod_d  = 64'(second_val) * 64'(top_val);
              state_d = S_MUL;
            end
          end
          OP_DIV: begin
            if (below_two) begin
              status_d = ST_UNDERFLOW;
            end else if (top_val == '0) begin
              status_d = ST_DIVZERO;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          OP_OUT: begin
            if (count_q == '0) begin
              status_d = ST_UNDERFLOW;
            end else begin
              status_d = ST_OUTPUT;
              res_d    = top_val;
            end
          end
          OP_HALT: status_d = ST_HALTED;
          default: status_d = ST_INVALID;
        endcase
      end
      S_MUL: begin
        // Arithmetic shift of the product floors toward minus infinity.
        res_d   = sat_q(wide_t'($signed(prod_q[63:16])));
        state_d = S_FINISH;
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = div_quo;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          case (status_q)
            ST_OK: begin
              if (op_q == OP_PUSH) begin
                top_cmd  = CELL_PUSH;
                rest_cmd = CELL_PUSH;
                count_d  = count_q + CNT_W'(1);
              end else begin
                // Binary operation: the result replaces the second entry.
                top_cmd  = CELL_PUSH;
                rest_cmd = CELL_POP;
                count_d  = count_q - CNT_W'(1);
              end
            end
            ST_OUTPUT: begin
              top_cmd  = CELL_POP;
              rest_cmd = CELL_POP;
              count_d  = count_q - CNT_W'(1);
            end
            ST_HALTED: count_d = '0;
            default:   count_d = count_q;
          endcase
          out_valid_d             = 1'b1;
          out_d.status            = status_q;
          out_d.result_value      = (status_q == ST_OUTPUT) ? res_q : '0;
          out_d.stack_level       = LEVEL_W'(count_d);
          state_d                 = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    op_q     <= op_d;
    imm_q    <= imm_d;
    status_q <= status_d;
    res_q    <= res_d;
    prod_q   <= prod_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count exceeds the stack depth");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_output_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && status_q == ST_OUTPUT) |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("output beat did not pop one entry");

  a_halt_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && status_q == ST_HALTED) |=> count_q == '0 && out_q.stack_level == '0)
    else $error("halt left entries on the stack");

endmodule

// File: tb/calc_checker.sv
`timescale 1ns / 100ps

module calc_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  smc_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  smc_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o
);

  import smc_pkg::*;

  localparam longint Q16_MAX = 64'sd2147483647;
  localparam longint Q16_MIN = -64'sd2147483648;

  q16_t        calc_stack [STACK_DEPTH];
  int unsigned calc_depth;
  out_t        expected_results [$];
  out_t        want;
  int          fail_count = 0;
  int          pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  function automatic q16_t clamp_q16(input longint v);
    q16_t r;
    if (v > Q16_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < Q16_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Runs one instruction on the shadow stack and returns the status beat it should produce.
  function automatic out_t exec_instruction(input in_t ins);
    out_t   res;
    q16_t   top_v;
    q16_t   second_v;
    longint wide;
    res.status       = ST_OK;
    res.result_value = '0;
    case (ins.operation)
      OP_PUSH: begin
        if (calc_depth >= STACK_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          calc_stack[calc_depth] = ins.immediate;
          calc_depth++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (calc_depth < 2) begin
          res.status = ST_UNDERFLOW;
        end else begin
          top_v    = calc_stack[calc_depth - 1];
          second_v = calc_stack[calc_depth - 2];
          if (ins.operation == OP_DIV && top_v == 0) begin
            res.status = ST_DIVZERO;
          end else begin
            case (ins.operation)
              OP_ADD: begin
                wide = longint'(second_v) + longint'(top_v);
              end
              OP_SUB: begin
                wide = longint'(second_v) - longint'(top_v);
              end
              OP_MUL: begin
                // The arithmetic shift floors, which is the required rounding.
                wide = (longint'(second_v) * longint'(top_v)) >>> 16;
              end
              default: begin
                wide = (longint'(second_v) * 65536) / longint'(top_v);
              end
            endcase
            calc_depth--;
            calc_stack[calc_depth - 1] = clamp_q16(wide);
          end
        end
      end
      OP_OUT: begin
        if (calc_depth == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          calc_depth--;
          res.result_value = calc_stack[calc_depth];
          res.status       = ST_OUTPUT;
        end
      end
      OP_HALT: begin
        calc_depth = 0;
        res.status = ST_HALTED;
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
    res.stack_level = calc_depth[LEVEL_W-1:0];
    return res;
  endfunction

  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      calc_depth = 0;
      expected_results.delete();
      pending = 0;
    end else begin
      // Results are checked before the new input beat is predicted; no beat can
      // come back in the same cycle it went in.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_failure($sformatf("result beat with nothing outstanding: status %0d value %h level %0d",
                                   out_data_i.status, out_data_i.result_value,
                                   out_data_i.stack_level));
        end else begin
          want = expected_results.pop_front();
          if (want.status !== out_data_i.status ||
              want.result_value !== out_data_i.result_value ||
              want.stack_level !== out_data_i.stack_level) begin
            report_failure($sformatf({"mismatch: expected status %0d value %h level %0d,",
                                      " got status %0d value %h level %0d"},
                                     want.status, want.result_value, want.stack_level,
                                     out_data_i.status, out_data_i.result_value,
                                     out_data_i.stack_level));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(exec_instruction(in_data_i));
      end
      pending = expected_results.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  import smc_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_OFF     = 400;
  localparam int DRAIN_CYCLES = 60;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  int   fail_count;
  int   pending;
  bit   sender_dense;

  stack_machine_calculator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  calc_checker u_calc_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Values that stay in range under multiply and divide, plus the
  // extremes, zero and fully random words.
  function automatic q16_t pick_value();
    q16_t v;
    case ($urandom_range(0, 9))
      0: begin
        v = '0;
      end
      1: begin
        v = 32'sh7FFF_FFFF;
      end
      2: begin
        v = 32'sh8000_0000;
      end
      3: begin
        v = ($urandom_range(0, 1) != 0) ? 32'sh0001_0000 : 32'shFFFF_FFFF;
      end
      4, 5, 6: begin
        v = q16_t'($urandom_range(0, 32'h000F_FFFF));
        if ($urandom_range(0, 1) != 0) begin
          v = -v;
        end
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  function automatic op_e pick_binary();
    op_e op;
    case ($urandom_range(0, 3))
      0:       op = OP_ADD;
      1:       op = OP_SUB;
      2:       op = OP_MUL;
      default: op = OP_DIV;
    endcase
    return op;
  endfunction

  task automatic send_instruction(input op_e op, input q16_t value);
    int gap;
    gap = sender_dense ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {op, value};
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int  seg_left;
    int  roll;
    bit  fill_mode;
    op_e op;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    sender_dense = 1'b0;
    seg_left     = 0;
    fill_mode    = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_instruction(OP_INVALID, $urandom);
    send_instruction(OP_OUT, $urandom);
    send_instruction(OP_ADD, $urandom);
    send_instruction(OP_PUSH, 32'sh7FFF_FFFF);
    send_instruction(OP_SUB, $urandom);
    send_instruction(OP_PUSH, 32'sh7FFF_FFFF);
    send_instruction(OP_ADD, $urandom);
    send_instruction(OP_PUSH, 32'sh8000_0000);
    send_instruction(OP_SUB, $urandom);
    send_instruction(OP_PUSH, 32'sh8000_0000);
    send_instruction(OP_MUL, $urandom);
    send_instruction(OP_PUSH, '0);
    send_instruction(OP_DIV, $urandom);
    send_instruction(OP_OUT, $urandom);
    send_instruction(OP_PUSH, 32'shFFFF_FFFF);
    send_instruction(OP_DIV, $urandom);
    send_instruction(OP_PUSH, 32'shFFFF_FFFF);
    send_instruction(OP_MUL, $urandom);
    send_instruction(OP_PUSH, 32'sh0003_0000);
    send_instruction(OP_DIV, $urandom);
    send_instruction(OP_PUSH, 32'shFFFF_FFFF);
    send_instruction(OP_HALT, $urandom);

    // Random segments either build the stack up to overflow or
    // drain it toward underflow and halt.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        seg_left     = $urandom_range(20, 45);
        fill_mode    = (n == 0) || ($urandom_range(0, 1) == 1);
        sender_dense = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      roll = $urandom_range(0, 99);
      if (fill_mode) begin
        if (roll < 75) begin
          op = OP_PUSH;
        end else if (roll < 90) begin
          op = pick_binary();
        end else if (roll < 98) begin
          op = OP_OUT;
        end else begin
          op = OP_INVALID;
        end
      end else begin
        if (roll < 30) begin
          op = OP_PUSH;
        end else if (roll < 70) begin
          op = pick_binary();
        end else if (roll < 92) begin
          op = OP_OUT;
        end else if (roll < 96) begin
          op = OP_HALT;
        end else begin
          op = OP_INVALID;
        end
      end
      send_instruction(op, (op == OP_PUSH) ? pick_value() : q16_t'($urandom));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: random stalls per beat, dense stretches, and one long hold-off
  // so the block backs up and stops taking input beats.
  initial begin
    int stall;
    int results_seen;
    bit held;
    bit receiver_dense;
    out_ready      <= 1'b0;
    results_seen   = 0;
    held           = 1'b0;
    receiver_dense = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (results_seen % 60 == 0) begin
        receiver_dense = ($urandom_range(0, 3) == 0);
      end
      if (!held && results_seen == 150) begin
        held  = 1'b1;
        stall = HOLD_OFF;
      end else begin
        stall = receiver_dense ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
